### sv/cpl_pkg.sv
`default_nettype none
package cpl_pkg;

  // Field and datapath widths.
  localparam int CoordW  = 16;
  localparam int DiffW   = CoordW + 1;
  localparam int SqW     = 2 * DiffW;
  localparam int SumW    = SqW + 2;
  localparam int ProdW   = 2 * SumW;
  localparam int NumW    = ProdW + 1;
  localparam int DenW    = ProdW;
  localparam int ScaledW = NumW + DiffW;
  localparam int QuotW   = 21;
  localparam int OffW    = QuotW + 1;
  localparam int RemW    = DenW + 1 + QuotW;
  localparam int CfgW    = 32;
  localparam int CfgIdxW = 1;

  // Pipeline depths: dot products and determinant, then the divider.
  localparam int FrontStages = 7;
  localparam int DivStages   = 2 + QuotW;

  // Largest offset magnitude that a division may give.
  localparam logic [QuotW-1:0] MagLimit = QuotW'(1) << (QuotW - 1);

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgLengthThr   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgParallelThr = 1'd1;

  typedef struct packed {
    logic signed [CoordW-1:0] line1_start_x;
    logic signed [CoordW-1:0] line1_start_y;
    logic signed [CoordW-1:0] line1_start_z;
    logic signed [CoordW-1:0] line1_end_x;
    logic signed [CoordW-1:0] line1_end_y;
    logic signed [CoordW-1:0] line1_end_z;
    logic signed [CoordW-1:0] line2_start_x;
    logic signed [CoordW-1:0] line2_start_y;
    logic signed [CoordW-1:0] line2_start_z;
    logic signed [CoordW-1:0] line2_end_x;
    logic signed [CoordW-1:0] line2_end_y;
    logic signed [CoordW-1:0] line2_end_z;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] near1_x;
    logic signed [CoordW-1:0] near1_y;
    logic signed [CoordW-1:0] near1_z;
    logic signed [CoordW-1:0] near2_x;
    logic signed [CoordW-1:0] near2_y;
    logic signed [CoordW-1:0] near2_z;
    logic                     found;
  } out_t;

  // Start points and the found flag, carried beside the arithmetic.
  typedef struct packed {
    logic [2:0][CoordW-1:0] p1;
    logic [2:0][CoordW-1:0] p3;
    logic                   found;
  } side_t;

endpackage
`default_nettype wire

### sv/cpl_front.sv
`default_nettype none
module cpl_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire logic [cpl_pkg::CfgW-1:0]             len_thr_i,
  input  wire logic [cpl_pkg::CfgW-1:0]             par_thr_i,
  input  wire cpl_pkg::in_t                         in_i,
  output logic signed [cpl_pkg::ScaledW-1:0]        scaled_o [6],
  output logic        [cpl_pkg::DenW-1:0]           den_o,
  output cpl_pkg::side_t                            side_o
);

  localparam int DiffW   = cpl_pkg::DiffW;
  localparam int SqW     = cpl_pkg::SqW;
  localparam int SumW    = cpl_pkg::SumW;
  localparam int ProdW   = cpl_pkg::ProdW;
  localparam int NumW    = cpl_pkg::NumW;
  localparam int DenW    = cpl_pkg::DenW;
  localparam int ScaledW = cpl_pkg::ScaledW;
  localparam int CoordW  = cpl_pkg::CoordW;

  // Numerator split for the scaling multiply: unsigned low part, signed high part.
  localparam int LoW     = 37;
  localparam int HiW     = NumW - LoW;
  localparam int PartLoW = LoW + 1 + DiffW;
  localparam int PartHiW = HiW + DiffW;

  logic signed [CoordW-1:0] a1 [3];
  logic signed [CoordW-1:0] a2 [3];
  logic signed [CoordW-1:0] b1 [3];
  logic signed [CoordW-1:0] b2 [3];

  // Stage registers.
  logic signed [DiffW-1:0] u_q [3];
  logic signed [DiffW-1:0] v_q [3];
  logic signed [DiffW-1:0] w_q [3];
  logic signed [SqW-1:0]   uu_p_q [3];
  logic signed [SqW-1:0]   vv_p_q [3];
  logic signed [SqW-1:0]   wv_p_q [3];
  logic signed [SqW-1:0]   uv_p_q [3];
  logic signed [SqW-1:0]   wu_p_q [3];
  logic signed [SumW-1:0]  uu_q, vv_q, wv_q, uv_q, wu_q;
  logic                    deg4_q, deg5_q;
  logic signed [ProdW-1:0] uuvv_q, uvuv_q, wvuv_q, wuvv_q, wvuu_q, wuuv_q;
  logic        [DenW-1:0]  den5_q, den6_q, den7_q;
  logic signed [NumW-1:0]  numa_q, numb_q;
  logic signed [PartLoW-1:0] lo_q [6];
  logic signed [PartHiW-1:0] hi_q [6];
  logic signed [ScaledW-1:0] scaled_q [6];
  logic [5:0][DiffW-1:0]   dir_q [2:5];
  cpl_pkg::side_t          side_q [1:7];

  logic signed [NumW-1:0]  den_diff;
  logic        [NumW-1:0]  den_abs;
  logic                    par;

  assign a1[0] = in_i.line1_start_x;
  assign a1[1] = in_i.line1_start_y;
  assign a1[2] = in_i.line1_start_z;
  assign a2[0] = in_i.line1_end_x;
  assign a2[1] = in_i.line1_end_y;
  assign a2[2] = in_i.line1_end_z;
  assign b1[0] = in_i.line2_start_x;
  assign b1[1] = in_i.line2_start_y;
  assign b1[2] = in_i.line2_start_z;
  assign b2[0] = in_i.line2_end_x;
  assign b2[1] = in_i.line2_end_y;
  assign b2[2] = in_i.line2_end_z;

  // Stage 1: direction vectors and the offset between start points.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= DiffW'(a2[i]) - DiffW'(a1[i]);
        v_q[i] <= DiffW'(b2[i]) - DiffW'(b1[i]);
        w_q[i] <= DiffW'(a1[i]) - DiffW'(b1[i]);
        side_q[1].p1[i] <= a1[i];
        side_q[1].p3[i] <= b1[i];
      end
      side_q[1].found <= 1'b0;
    end
  end

  // Stage 2: element products of the five dot products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        uu_p_q[i] <= u_q[i] * u_q[i];
        vv_p_q[i] <= v_q[i] * v_q[i];
        wv_p_q[i] <= w_q[i] * v_q[i];
        uv_p_q[i] <= u_q[i] * v_q[i];
        wu_p_q[i] <= w_q[i] * u_q[i];
        dir_q[2][i]     <= u_q[i];
        dir_q[2][3 + i] <= v_q[i];
      end
      side_q[2] <= side_q[1];
    end
  end

  // Stage 3: dot product sums.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      uu_q <= SumW'(uu_p_q[0]) + SumW'(uu_p_q[1]) + SumW'(uu_p_q[2]);
      vv_q <= SumW'(vv_p_q[0]) + SumW'(vv_p_q[1]) + SumW'(vv_p_q[2]);
      wv_q <= SumW'(wv_p_q[0]) + SumW'(wv_p_q[1]) + SumW'(wv_p_q[2]);
      uv_q <= SumW'(uv_p_q[0]) + SumW'(uv_p_q[1]) + SumW'(uv_p_q[2]);
      wu_q <= SumW'(wu_p_q[0]) + SumW'(wu_p_q[1]) + SumW'(wu_p_q[2]);
      dir_q[3]  <= dir_q[2];
      side_q[3] <= side_q[2];
    end
  end

  // Stage 4: cross products for the determinant and both numerators.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      uuvv_q <= uu_q * vv_q;
      uvuv_q <= uv_q * uv_q;
      wvuv_q <= wv_q * uv_q;
      wuvv_q <= wu_q * vv_q;
      wvuu_q <= wv_q * uu_q;
      wuuv_q <= wu_q * uv_q;
      deg4_q <= ($unsigned(uu_q) < SumW'(len_thr_i)) ||
                ($unsigned(vv_q) < SumW'(len_thr_i));
      dir_q[4]  <= dir_q[3];
      side_q[4] <= side_q[3];
    end
  end

  // Stage 5: determinant magnitude and the two numerators.
  always_comb begin
    den_diff = NumW'(uuvv_q) - NumW'(uvuv_q);
    den_abs  = den_diff[NumW-1] ? $unsigned(-den_diff) : $unsigned(den_diff);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den5_q <= den_abs[DenW-1:0];
      numa_q <= NumW'(wvuv_q) - NumW'(wuvv_q);
      numb_q <= NumW'(wvuu_q) - NumW'(wuuv_q);
      deg5_q <= deg4_q;
      dir_q[5]  <= dir_q[4];
      side_q[5] <= side_q[4];
    end
  end

  // Stage 6: partial products of each numerator half and direction component;
  // final validity.
  assign par = (den5_q == '0) || (den5_q < DenW'(par_thr_i));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i]     <= $signed({1'b0, numa_q[LoW-1:0]}) * $signed(dir_q[5][i]);
        lo_q[3 + i] <= $signed({1'b0, numb_q[LoW-1:0]}) * $signed(dir_q[5][3 + i]);
        hi_q[i]     <= $signed(numa_q[NumW-1:LoW]) * $signed(dir_q[5][i]);
        hi_q[3 + i] <= $signed(numb_q[NumW-1:LoW]) * $signed(dir_q[5][3 + i]);
      end
      den6_q          <= den5_q;
      side_q[6].p1    <= side_q[5].p1;
      side_q[6].p3    <= side_q[5].p3;
      side_q[6].found <= !deg5_q && !par;
    end
  end

  // Stage 7: combine the partial products into the scaled numerators.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 6; i++) begin
        scaled_q[i] <= (ScaledW'(hi_q[i]) <<< LoW) + ScaledW'(lo_q[i]);
      end
      den7_q    <= den6_q;
      side_q[7] <= side_q[6];
    end
  end

  assign scaled_o = scaled_q;
  assign den_o    = den7_q;
  assign side_o   = side_q[7];

endmodule
`default_nettype wire

### sv/cpl_div.sv
`default_nettype none
module cpl_div (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [cpl_pkg::ScaledW-1:0]  num_i,
  input  wire logic        [cpl_pkg::DenW-1:0]     den_i,
  output logic signed      [cpl_pkg::OffW-1:0]     off_o
);

  localparam int ScaledW = cpl_pkg::ScaledW;
  localparam int DenW    = cpl_pkg::DenW;
  localparam int QuotW   = cpl_pkg::QuotW;
  localparam int RemW    = cpl_pkg::RemW;
  localparam int OffW    = cpl_pkg::OffW;

  logic [ScaledW:0]   mag;
  logic [RemW-1:0]    nn0_q;
  logic [DenW:0]      d20_q;
  logic               neg0_q;

  logic [RemW-1:0]    r_q   [0:QuotW];
  logic [DenW:0]      d2_q  [0:QuotW];
  logic [QuotW-1:0]   q_q   [0:QuotW];
  logic               neg_q [0:QuotW];
  logic               ovf_q [0:QuotW];

  logic [QuotW-1:0]   mag_out;

  // Rounded division: floor((2|n| + d) / 2d).
  assign mag = num_i[ScaledW-1] ? $unsigned(-(ScaledW+1)'(num_i))
                                : $unsigned((ScaledW+1)'(num_i));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nn0_q  <= RemW'({mag, 1'b0}) + RemW'(den_i);
      d20_q  <= {den_i, 1'b0};
      neg0_q <= num_i[ScaledW-1];
    end
  end

  // Quotients that do not fit the quotient width saturate.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= nn0_q;
      d2_q[0]  <= d20_q;
      q_q[0]   <= '0;
      neg_q[0] <= neg0_q;
      ovf_q[0] <= nn0_q >= (RemW'(d20_q) << QuotW);
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < QuotW; j++) begin : g_bit
    localparam int K = QuotW - 1 - j;
    logic [RemW-1:0] sub;
    logic            fit;

    always_comb begin
      sub = RemW'(d2_q[j]) << K;
      fit = r_q[j] >= sub;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j+1]   <= fit ? r_q[j] - sub : r_q[j];
        q_q[j+1]   <= q_q[j] | (QuotW'(fit) << K);
        d2_q[j+1]  <= d2_q[j];
        neg_q[j+1] <= neg_q[j];
        ovf_q[j+1] <= ovf_q[j];
      end
    end
  end

  // Limit the magnitude and restore the sign.
  assign mag_out = (ovf_q[QuotW] || q_q[QuotW] > cpl_pkg::MagLimit) ?
                   cpl_pkg::MagLimit : q_q[QuotW];
  assign off_o   = neg_q[QuotW] ? -$signed(OffW'(mag_out)) : $signed(OffW'(mag_out));

endmodule
`default_nettype wire

### sv/closest_points_two_lines.sv
// Throughput: one line pair per cycle while the skid register is free; every
// stage is registered and the rounding division produces one quotient bit per
// pipeline stage.
// Two result registers follow the pipeline, so a stalled output still takes
// one more result before the pipeline holds.
// Reset clears all valid bits and loads the default thresholds.
`default_nettype none
module closest_points_two_lines (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire cpl_pkg::in_t                     in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output cpl_pkg::out_t                         out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [cpl_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [cpl_pkg::CfgW-1:0]         cfg_data_i
);

  localparam int Stages  = cpl_pkg::FrontStages + cpl_pkg::DivStages;
  localparam int DivLat  = cpl_pkg::DivStages;
  localparam int CoordW  = cpl_pkg::CoordW;
  localparam int OffW    = cpl_pkg::OffW;
  localparam int SumOutW = OffW + 1;

  logic                        en;
  logic [cpl_pkg::CfgW-1:0]    len_thr_q, par_thr_q;
  logic [Stages-1:0]           vld_q;

  logic signed [cpl_pkg::ScaledW-1:0] scaled [6];
  logic        [cpl_pkg::DenW-1:0]    den;
  cpl_pkg::side_t                     side;
  cpl_pkg::side_t                     side_q [DivLat];
  logic signed [OffW-1:0]             off [6];

  cpl_pkg::out_t res;
  cpl_pkg::out_t out_q, skid_q;
  logic          out_vld_q, skid_vld_q;
  logic          res_vld, take;

  logic signed [CoordW-1:0] pt [6];
  logic signed [CoordW-1:0] near [6];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_thr_q <= 32'd7;
      par_thr_q <= 32'd429497;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpl_pkg::CfgLengthThr:   len_thr_q <= cfg_data_i;
        cpl_pkg::CfgParallelThr: par_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves while the skid register is free.
  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  cpl_front u_front (
    .clk_i     (clk_i),
    .en_i      (en),
    .len_thr_i (len_thr_q),
    .par_thr_i (par_thr_q),
    .in_i      (in_data_i),
    .scaled_o  (scaled),
    .den_o     (den),
    .side_o    (side)
  );

  for (genvar i = 0; i < 6; i++) begin : g_div
    cpl_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (scaled[i]),
      .den_i (den),
      .off_o (off[i])
    );
  end

  // Start points and flag wait beside the dividers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side;
      for (int k = 1; k < DivLat; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Add offsets to start points and saturate to Q8.8.
  always_comb begin
    logic signed [SumOutW-1:0] s;
    for (int i = 0; i < 3; i++) begin
      pt[i]     = $signed(side_q[DivLat-1].p1[i]);
      pt[3 + i] = $signed(side_q[DivLat-1].p3[i]);
    end
    for (int i = 0; i < 6; i++) begin
      s = SumOutW'(pt[i]) + SumOutW'(off[i]);
      if (!side_q[DivLat-1].found) begin
        near[i] = '0;
      end else if (s > SumOutW'(32767)) begin
        near[i] = 16'sh7fff;
      end else if (s < -SumOutW'(32768)) begin
        near[i] = 16'sh8000;
      end else begin
        near[i] = s[CoordW-1:0];
      end
    end
    res.near1_x = near[0];
    res.near1_y = near[1];
    res.near1_z = near[2];
    res.near2_x = near[3];
    res.near2_y = near[4];
    res.near2_z = near[5];
    res.found   = side_q[DivLat-1].found;
  end

  assign res_vld = vld_q[Stages-1];
  assign take    = out_vld_q && out_ready_i;

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        out_q      <= skid_q;
        skid_vld_q <= 1'b0;
      end
    end else if (res_vld) begin
      if (!out_vld_q || take) begin
        out_q     <= res;
        out_vld_q <= 1'b1;
      end else begin
        skid_q     <= res;
        skid_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // The skid register only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a result with the output empty");

  // A finished result meeting a blocked output lands in the skid register.
  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld && !skid_vld_q && out_vld_q && !out_ready_i) |=> skid_vld_q)
    else $error("finished result dropped at the output");

  // A result without found carries zero points.
  a_zero_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.found) |->
      (out_q.near1_x == '0 && out_q.near1_y == '0 && out_q.near1_z == '0 &&
       out_q.near2_x == '0 && out_q.near2_y == '0 && out_q.near2_z == '0))
    else $error("degenerate result has nonzero points");

endmodule
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb;

  localparam int CoordW  = cpl_pkg::CoordW;
  localparam int CfgW    = cpl_pkg::CfgW;
  localparam int CfgIdxW = cpl_pkg::CfgIdxW;

  typedef logic signed [127:0] wide_t;

  // Idle time from the last result to a register write, past the block latency.
  localparam int DrainCycles = 40;
  localparam int StallLimit  = 5000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  cpl_pkg::in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  cpl_pkg::out_t out_data_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  closest_points_two_lines dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  cpl_pkg::in_t  pending_pairs[$];
  cpl_pkg::out_t expected_points[$];
  logic [CfgW-1:0] len_thr;
  logic [CfgW-1:0] par_thr;
  int   errors;
  int   results_seen;
  int   found_seen;
  int   stall_cycles;
  int   in_gap;
  int   out_gap;
  bit   calm;
  logic in_taken;

  // Rounded offset n/d, ties away from zero, magnitude limited to 2^20.
  function automatic wide_t round_offset(wide_t n, wide_t d);
    wide_t mag;
    wide_t q;
    mag = (n < 0) ? -n : n;
    q = ((mag <<< 1) + d) / (d <<< 1);
    if (q > (wide_t'(1) <<< 20)) q = wide_t'(1) <<< 20;
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic [CoordW-1:0] clamp_coord(wide_t x);
    if (x > 32767) return 16'sd32767;
    if (x < -32768) return -16'sd32768;
    return x[CoordW-1:0];
  endfunction

  // Nearest points of one line pair under the current thresholds.
  function automatic cpl_pkg::out_t predict_nearest(cpl_pkg::in_t r, logic [CfgW-1:0] lt,
                                                    logic [CfgW-1:0] pt);
    wide_t p1[3];
    wide_t p2[3];
    wide_t p3[3];
    wide_t p4[3];
    wide_t u[3];
    wide_t v[3];
    wide_t w[3];
    wide_t uu, vv, wv, uv, wu, den, numa, numb;
    cpl_pkg::out_t o;
    p1[0] = r.line1_start_x; p1[1] = r.line1_start_y; p1[2] = r.line1_start_z;
    p2[0] = r.line1_end_x;   p2[1] = r.line1_end_y;   p2[2] = r.line1_end_z;
    p3[0] = r.line2_start_x; p3[1] = r.line2_start_y; p3[2] = r.line2_start_z;
    p4[0] = r.line2_end_x;   p4[1] = r.line2_end_y;   p4[2] = r.line2_end_z;
    o = '0;
    uu = 0; vv = 0; wv = 0; uv = 0; wu = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = p2[i] - p1[i];
      v[i] = p4[i] - p3[i];
      w[i] = p1[i] - p3[i];
      uu += u[i] * u[i];
      vv += v[i] * v[i];
      wv += w[i] * v[i];
      uv += u[i] * v[i];
      wu += w[i] * u[i];
    end
    if (uu < $signed({96'd0, lt}) || vv < $signed({96'd0, lt})) return o;
    den = uu * vv - uv * uv;
    if (den < 0) den = -den;
    if (den == 0 || den < $signed({96'd0, pt})) return o;
    numa = wv * uv - wu * vv;
    numb = wv * uu - wu * uv;
    o.near1_x = clamp_coord(p1[0] + round_offset(numa * u[0], den));
    o.near1_y = clamp_coord(p1[1] + round_offset(numa * u[1], den));
    o.near1_z = clamp_coord(p1[2] + round_offset(numa * u[2], den));
    o.near2_x = clamp_coord(p3[0] + round_offset(numb * v[0], den));
    o.near2_y = clamp_coord(p3[1] + round_offset(numb * v[1], den));
    o.near2_z = clamp_coord(p3[2] + round_offset(numb * v[2], den));
    o.found = 1'b1;
    return o;
  endfunction

  function automatic int next_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [CoordW-1:0] near_coord(int span);
    return CoordW'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Random pair: full range, small, nearly parallel or nearly degenerate.
  function automatic cpl_pkg::in_t random_pair();
    cpl_pkg::in_t r;
    int kind;
    int k;
    kind = $urandom_range(0, 9);
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (kind >= 2 && kind <= 6) begin
      r.line1_start_x = near_coord(2048); r.line1_start_y = near_coord(2048);
      r.line1_start_z = near_coord(2048); r.line1_end_x = near_coord(2048);
      r.line1_end_y = near_coord(2048);   r.line1_end_z = near_coord(2048);
      r.line2_start_x = near_coord(2048); r.line2_start_y = near_coord(2048);
      r.line2_start_z = near_coord(2048); r.line2_end_x = near_coord(2048);
      r.line2_end_y = near_coord(2048);   r.line2_end_z = near_coord(2048);
    end else if (kind == 7 || kind == 8) begin
      k = $urandom_range(1, 3);
      r.line1_start_x = near_coord(1000); r.line1_start_y = near_coord(1000);
      r.line1_start_z = near_coord(1000);
      r.line1_end_x = r.line1_start_x + near_coord(300);
      r.line1_end_y = r.line1_start_y + near_coord(300);
      r.line1_end_z = r.line1_start_z + near_coord(300);
      r.line2_start_x = near_coord(1000); r.line2_start_y = near_coord(1000);
      r.line2_start_z = near_coord(1000);
      r.line2_end_x = r.line2_start_x + CoordW'(k * (r.line1_end_x - r.line1_start_x)) +
                      near_coord(1);
      r.line2_end_y = r.line2_start_y + CoordW'(k * (r.line1_end_y - r.line1_start_y)) +
                      near_coord(1);
      r.line2_end_z = r.line2_start_z + CoordW'(k * (r.line1_end_z - r.line1_start_z)) +
                      near_coord(1);
    end else if (kind == 9) begin
      r.line1_end_x = r.line1_start_x + near_coord(2);
      r.line1_end_y = r.line1_start_y + near_coord(2);
      r.line1_end_z = r.line1_start_z + near_coord(2);
    end
    return r;
  endfunction

  function automatic cpl_pkg::in_t make_pair(int a0, int a1, int a2, int b0, int b1, int b2,
                                             int c0, int c1, int c2, int d0, int d1, int d2);
    cpl_pkg::in_t r;
    r.line1_start_x = CoordW'(a0); r.line1_start_y = CoordW'(a1);
    r.line1_start_z = CoordW'(a2);
    r.line1_end_x   = CoordW'(b0); r.line1_end_y   = CoordW'(b1);
    r.line1_end_z   = CoordW'(b2);
    r.line2_start_x = CoordW'(c0); r.line2_start_y = CoordW'(c1);
    r.line2_start_z = CoordW'(c2);
    r.line2_end_x   = CoordW'(d0); r.line2_end_y   = CoordW'(d1);
    r.line2_end_z   = CoordW'(d2);
    return r;
  endfunction

  task automatic check_field(string name, logic [CoordW-1:0] exp, logic [CoordW-1:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
    end
  endtask

  // Wait for an idle block, then load both thresholds.
  task automatic load_thresholds(logic [CfgW-1:0] lt, logic [CfgW-1:0] pt);
    wait (pending_pairs.size() == 0 && !in_valid_i && expected_points.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = cpl_pkg::CfgLengthThr; cfg_data_i = lt;
    @(negedge clk_i);
    cfg_idx_i = cpl_pkg::CfgParallelThr; cfg_data_i = pt;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    len_thr = lt;
    par_thr = pt;
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pending_pairs.push_back(random_pair());
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Request driver: holds each request until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (pending_pairs.size() > 0) begin
        in_data_i <= pending_pairs.pop_front();
        in_valid_i <= 1'b1;
        in_gap = next_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output back-pressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_ready_i <= 1'b0;
        out_gap--;
      end else begin
        out_ready_i <= 1'b1;
        out_gap = next_gap();
      end
    end
  end

  // Monitor: predicts on accepted requests, checks results, watches for stalls.
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        expected_points.push_back(predict_nearest(in_data_i, len_thr, par_thr));
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_points.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_data_o);
        end else begin
          cpl_pkg::out_t e;
          e = expected_points.pop_front();
          check_field("near1_x", e.near1_x, out_data_o.near1_x);
          check_field("near1_y", e.near1_y, out_data_o.near1_y);
          check_field("near1_z", e.near1_z, out_data_o.near1_z);
          check_field("near2_x", e.near2_x, out_data_o.near2_x);
          check_field("near2_y", e.near2_y, out_data_o.near2_y);
          check_field("near2_z", e.near2_z, out_data_o.near2_z);
          check_field("found", 16'(e.found), 16'(out_data_o.found));
          if (e.found) found_seen++;
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
      else if (stall_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end else stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = cpl_pkg::CfgLengthThr;
    cfg_data_i = '0;
    in_taken = 1'b0;
    len_thr = 32'd7;
    par_thr = 32'd429497;
    errors = 0; results_seen = 0; found_seen = 0; stall_cycles = 0;
    in_gap = 0; out_gap = 0; calm = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed pairs under the reset thresholds.
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 256, 0, 0, 0, 0, 256, 0, 256, 256));
    pending_pairs.push_back(make_pair(-256, 0, 0, 256, 0, 0, 0, -256, 512, 0, 256, 512));
    pending_pairs.push_back(make_pair(0, 0, 0, 256, 256, 0, 512, 0, 0, 768, 256, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 1, 0, 0, 0, 0, 256, 0, 256, 256));
    pending_pairs.push_back(make_pair(0, 0, 0, 2, 1, 1, 0, 0, 256, 0, 256, 256));
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, 32767,
                                      32767, -32768, 0, -32768, 32767, 0));
    pending_pairs.push_back(make_pair(32767, 32767, 32767, -32768, -32768, -32768,
                                      -32768, 32767, -32768, 32767, -32768, 32767));
    pending_pairs.push_back(make_pair(32767, 0, 0, 32767, 1, 0, -32768, 0, 0, -32768, 0, 1));
    pending_pairs.push_back(make_pair(0, 0, 0, 1, 1, 1, 100, 0, 0, 100, 1, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0));
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                                      32767, 32767, 32767, 32767, 32767, 32767));
    pending_pairs.push_back(make_pair(0, 0, 0, 1, 2, 3, 5, 5, 5, 6, 7, 8));
    pending_pairs.push_back(make_pair(30000, 0, 0, 30001, 0, 0, 0, 30000, 0, 0, 30000, 1));
    queue_random(380);

    calm = 1'b1;
    load_thresholds(32'd0, 32'd0);
    pending_pairs.push_back(make_pair(0, 0, 0, 256, 0, 0, 0, 0, 0, 512, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_random(390);

    calm = 1'b0;
    load_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(390);

    load_thresholds($urandom_range(0, 1000), $urandom_range(0, 1 << 24));
    queue_random(390);

    load_thresholds(32'd7, 32'd429497);
    queue_random(390);

    wait (pending_pairs.size() == 0 && !in_valid_i && expected_points.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Checked %0d line pairs over five threshold settings, %0d with points found.",
             results_seen, found_seen);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
